// ===== hdl/peak_triggered_delayed_pulse_macros.svh =====
// Assertion macros for the peak triggered delayed pulse block.
// Included by files that check their own logic; no other dependencies.
`ifndef PEAK_TRIGGERED_DELAYED_PULSE_MACROS_SVH
`define PEAK_TRIGGERED_DELAYED_PULSE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define PDP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled in reset.
`define PDP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PDP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PDP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/pdp_pkg.sv =====
// Shared types and constants for the peak triggered delayed pulse block.
// No dependencies.
`timescale 1ns / 1ps

package pdp_pkg;

   localparam int CFG_BITS       = 16;
   localparam int THR_BITS       = 11;
   localparam int FRAC_BITS      = 4;
   localparam int LEVEL_BITS     = THR_BITS + CFG_BITS + 1;
   localparam int TICK_BITS      = 17;
   localparam int PHASE_BITS     = 18;
   localparam int SPAN_BITS      = CFG_BITS + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MID_SCALE      = 100;

   localparam logic [CFG_BITS-1:0] MEAN_RESET  = 16'd0;
   localparam logic [CFG_BITS-1:0] SD_RESET    = 16'd16;
   localparam logic [THR_BITS-1:0] THR_RESET   = 11'd70;
   localparam logic [CFG_BITS-1:0] WIDTH_RESET = 16'd10;
   localparam logic [CFG_BITS-1:0] DELAY_RESET = 16'd0;
   localparam logic [CFG_BITS-1:0] HOLD_RESET  = 16'd0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MEAN,
      CSR_SD,
      CSR_THRESHOLD,
      CSR_TROUGH,
      CSR_WIDTH,
      CSR_DELAY,
      CSR_HOLDOFF
   } csr_index_type;

   // Settings as seen by the datapath, level and span precomputed.
   typedef struct packed {
      logic [CFG_BITS-1:0]          mean;
      logic signed [LEVEL_BITS-1:0] level;
      logic                         trough;
      logic [CFG_BITS-1:0]          delay;
      logic [SPAN_BITS-1:0]         span;
      logic [CFG_BITS-1:0]          holdoff;
   } cfg_type;

   typedef struct packed {
      logic armed;
      logic pulse;
   } stat_type;

endpackage

// ===== hdl/pdp_csr.sv =====
// Configuration registers with derived level and pulse span.
// Depends on pdp_pkg.
`timescale 1ns / 1ps

module pdp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pdp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pdp_pkg::CFG_BITS-1:0]        csr_data,
   output pdp_pkg::cfg_type                    cfg
);
   import pdp_pkg::*;

   logic [CFG_BITS-1:0]          mean_ff, sd_ff, width_ff, delay_ff, hold_ff;
   logic [THR_BITS-1:0]          thr_ff;
   logic                         trough_ff;
   logic [CFG_BITS-1:0]          sd_eff;
   logic signed [LEVEL_BITS-1:0] level;
   logic [SPAN_BITS-1:0]         span;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff   <= MEAN_RESET;
         sd_ff     <= SD_RESET;
         thr_ff    <= THR_RESET;
         trough_ff <= 1'b0;
         width_ff  <= WIDTH_RESET;
         delay_ff  <= DELAY_RESET;
         hold_ff   <= HOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MEAN:      mean_ff   <= csr_data;
            CSR_SD:        sd_ff     <= csr_data;
            CSR_THRESHOLD: thr_ff    <= csr_data[THR_BITS-1:0];
            CSR_TROUGH:    trough_ff <= csr_data[0];
            CSR_WIDTH:     width_ff  <= csr_data;
            CSR_DELAY:     delay_ff  <= csr_data;
            CSR_HOLDOFF:   hold_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // zero deviation counts as one
   assign sd_eff = (sd_ff == '0) ? CFG_BITS'(1) : sd_ff;
   // level and span follow the registers in the same cycle
   assign level  = LEVEL_BITS'($signed(thr_ff)) *
                   LEVEL_BITS'($signed({1'b0, sd_eff}));
   assign span   = SPAN_BITS'(delay_ff) + SPAN_BITS'(width_ff);

   assign cfg.mean    = mean_ff;
   assign cfg.level   = level;
   assign cfg.trough  = trough_ff;
   assign cfg.delay   = delay_ff;
   assign cfg.span    = span;
   assign cfg.holdoff = hold_ff;

endmodule

// ===== hdl/pdp_core.sv =====
// Sample window, extremum test, gap and phase counters, pulse line.
// Depends on pdp_pkg.
`timescale 1ns / 1ps

module pdp_core #(
   parameter int SAMPLE_BITS   = 12,
   parameter int MIN_GAP_TICKS = 100
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  pdp_pkg::cfg_type       cfg,
   output logic                   pulse_in,
   output logic                   trig,
   output pdp_pkg::stat_type      stat
);
   import pdp_pkg::*;

   localparam int CW = ((SAMPLE_BITS + FRAC_BITS > CFG_BITS) ?
                        SAMPLE_BITS + FRAC_BITS : CFG_BITS) + 2;
   localparam int PW = ((CW + 7 > LEVEL_BITS) ? CW + 7 : LEVEL_BITS) + 1;
   localparam logic signed [PW-1:0]       SCALE    = PW'(MID_SCALE);
   localparam logic [TICK_BITS-1:0]       MIN_GAP  = TICK_BITS'(MIN_GAP_TICKS);
   localparam logic [TICK_BITS-1:0]       TICK_MAX = '1;
   localparam logic [PHASE_BITS-1:0]      PHASE_MAX = '1;

   logic signed [CW-1:0] old_ff, mid_ff, new_ff, new_in;
   logic [TICK_BITS-1:0]  ticks_ff, ticks_t, ticks_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_t, phase_a, phase_in;
   logic                  armed_ff, armed_t, armed_in, pulse_ff;
   logic signed [PW-1:0]  mid_x, level_x;
   logic                  gap_ok, peak, dip, rise, fall;

   assign new_in = $signed(CW'({sample, FRAC_BITS'(0)})) - $signed(CW'(cfg.mean));

   // window after shift: oldest = mid_ff, middle = new_ff, newest = new_in
   assign mid_x   = PW'(new_ff) * SCALE;
   assign level_x = PW'(cfg.level);
   assign gap_ok  = (ticks_ff > MIN_GAP) && (ticks_ff > TICK_BITS'(cfg.holdoff));
   assign peak    = (mid_x > level_x) && (mid_ff < new_ff) && (new_ff > new_in);
   assign dip     = (mid_x < level_x) && (mid_ff > new_ff) && (new_ff < new_in);
   assign trig    = gap_ok && (cfg.trough ? dip : peak);

   always_comb begin
      ticks_t = trig ? '0 : ticks_ff;
      phase_t = trig ? '0 : phase_ff;
      armed_t = trig | armed_ff;
      rise    = !pulse_ff && armed_t && (phase_t > PHASE_BITS'(cfg.delay));
      fall    = !rise && armed_t && (phase_t > PHASE_BITS'(cfg.span));
      pulse_in = rise ? 1'b1 : (fall ? 1'b0 : pulse_ff);
      armed_in = fall ? 1'b0 : armed_t;
      phase_a  = fall ? '0 : phase_t;
      phase_in = (phase_a == PHASE_MAX) ? phase_a : phase_a + 1'b1;
      ticks_in = (ticks_t == TICK_MAX) ? ticks_t : ticks_t + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_ff   <= '0;
         mid_ff   <= '0;
         new_ff   <= '0;
         ticks_ff <= '0;
         phase_ff <= '0;
         armed_ff <= 1'b0;
         pulse_ff <= 1'b0;
      end else if (step) begin
         old_ff   <= mid_ff;
         mid_ff   <= new_ff;
         new_ff   <= new_in;
         ticks_ff <= ticks_in;
         phase_ff <= phase_in;
         armed_ff <= armed_in;
         pulse_ff <= pulse_in;
      end
   end

   // oldest slot feeds no decision logic; kept for window reset behavior
   logic unused_old;
   assign unused_old = ^old_ff;

   assign stat.armed = armed_ff;
   assign stat.pulse = pulse_ff | (unused_old & 1'b0);

endmodule

// ===== hdl/peak_triggered_delayed_pulse.sv =====
// Top level of the peak triggered delayed pulse block: input word register,
// datapath, result register and checks. Depends on pdp_pkg, pdp_csr, pdp_core
// and peak_triggered_delayed_pulse_macros.svh.
//
//   channel  | ports                          | direction
//   ---------+--------------------------------+----------
//   req      | req_valid/ready, req_sample    | in
//   rsp      | rsp_valid/ready, pulse, trig   | out
//   csr      | csr_valid/ready, index, data   | in
//
// One word per cycle sustained while results are taken; a word passes from
// acceptance to result through the input register, then the window/counter
// update into the result register. The state update loop closes through pdp_core.
// Reset is synchronous, active high; it restores register defaults and
// clears window, counters and the pulse line. No clearing pass.
// A stalled result holds in the output register while the input register
// still takes one more word; req_ready drops only when both are full.
`timescale 1ns / 1ps
`include "peak_triggered_delayed_pulse_macros.svh"

module peak_triggered_delayed_pulse #(
   parameter int SAMPLE_BITS   = 12,
   parameter int MIN_GAP_TICKS = 100
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pulse_level,
   output logic                                rsp_triggered,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pdp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pdp_pkg::CFG_BITS-1:0]        csr_data
);
   import pdp_pkg::*;

   cfg_type                cfg;
   stat_type               stat;
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic                   rsp_valid_ff, pulse_ff, trig_ff;
   logic                   advance, pulse_in, trig_in;

   // datapath step whenever a word waits and the result slot is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         smp_ff <= req_sample;
      end
   end

   pdp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pdp_core #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .MIN_GAP_TICKS (MIN_GAP_TICKS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .sample   (smp_ff),
      .cfg      (cfg),
      .pulse_in (pulse_in),
      .trig     (trig_in),
      .stat     (stat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pulse_ff <= pulse_in;
         trig_ff  <= trig_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pulse_level = pulse_ff;
   assign rsp_triggered   = trig_ff;

   // input side stalls only behind a full, stalled result slot
   `PDP_ASSERT_IMPL(a_ready_stall, clock, reset, !req_ready, in_valid_ff && rsp_valid_ff && !rsp_ready, "req_ready low without a stalled result")
   // a trigger always leaves the sequence armed
   `PDP_ASSERT_NEXT(a_trig_arms, clock, reset, advance && trig_in, stat.armed, "trigger did not arm the pulse")
   // the line is high only inside an armed sequence
   `PDP_ASSERT_IMPL(a_pulse_armed, clock, reset, stat.pulse, stat.armed, "pulse high while not armed")
   // every datapath step lands in the result slot
   `PDP_ASSERT_NEXT(a_step_result, clock, reset, advance, rsp_valid_ff, "result lost after step")

endmodule

// ===== bench/peak_triggered_delayed_pulse_tb.sv =====
// Testbench for peak_triggered_delayed_pulse: directed and random sample streams,
// each result word checked against an in-bench model of detector and pulse timer.
// Depends on pdp_pkg and the peak_triggered_delayed_pulse RTL.
`timescale 1ns / 1ps

module peak_triggered_delayed_pulse_tb;
   import pdp_pkg::*;

   localparam int SMP_BITS      = 12;
   localparam int GAP_TICKS     = 100;
   localparam int SETTLE_CYCLES = 4;   // pad after the queue drains
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;   // no register here

   // Live register copy, same field meaning as the CSR map.
   typedef struct packed {
      logic [CFG_BITS-1:0]        mean;
      logic [CFG_BITS-1:0]        sd;
      logic signed [THR_BITS-1:0] thr;
      logic                       trough;
      logic [CFG_BITS-1:0]        width;
      logic [CFG_BITS-1:0]        delay;
      logic [CFG_BITS-1:0]        hold;
   } pulse_settings_type;

   typedef struct packed {
      logic pulse_level;
      logic triggered;
   } tick_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SMP_BITS-1:0]       req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_pulse_level;
   logic                      rsp_triggered;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_data = '0;

   // Model state: settings, three-tap window of centered samples, counters.
   pulse_settings_type    cfg_now = {MEAN_RESET, SD_RESET, THR_RESET, 1'b0,
                                     WIDTH_RESET, DELAY_RESET, HOLD_RESET};
   logic signed [17:0]    win_old = '0;
   logic signed [17:0]    win_mid = '0;
   logic signed [17:0]    win_new = '0;
   logic [TICK_BITS-1:0]  since_trig = '0;
   logic [PHASE_BITS-1:0] phase_cnt = '0;
   logic                  armed_q = 1'b0;
   logic                  pulse_q = 1'b0;

   tick_result_type expected_q[$];   // one entry per accepted sample word
   int              errors = 0;
   bit              idle_on = 1'b1;  // random gaps on both channels
   int              stall_left = 0;

   peak_triggered_delayed_pulse #(
      .SAMPLE_BITS(SMP_BITS),
      .MIN_GAP_TICKS(GAP_TICKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pulse_level(rsp_pulse_level),
      .rsp_triggered(rsp_triggered),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Advance the model by one tick and return the word the block should emit.
   // Level test is exact: mid * 100 against threshold * sd, sd of zero acts as 1.
   function automatic tick_result_type predict_tick(input logic [SMP_BITS-1:0] smp);
      longint          sd_eff;
      longint          level;
      longint          mid;
      logic            gap_ok;
      logic            fire;
      tick_result_type r;
      sd_eff  = (cfg_now.sd == '0) ? 64'sd1 : longint'(cfg_now.sd);
      level   = longint'($signed(cfg_now.thr)) * sd_eff;
      win_old = win_mid;
      win_mid = win_new;
      win_new = 18'(longint'(smp) * 16 - longint'(cfg_now.mean));
      mid     = longint'(win_mid);
      gap_ok  = (since_trig > GAP_TICKS) && (since_trig > cfg_now.hold);
      if (!gap_ok)
         fire = 1'b0;
      else if (!cfg_now.trough)
         fire = (mid * 100 > level) && (win_old < win_mid) && (win_mid > win_new);
      else
         fire = (mid * 100 < level) && (win_old > win_mid) && (win_mid < win_new);
      // a retrigger restarts the phase count, line state untouched
      if (fire) begin
         since_trig = '0;
         phase_cnt  = '0;
         armed_q    = 1'b1;
      end
      if (!pulse_q && armed_q && phase_cnt > cfg_now.delay) begin
         pulse_q = 1'b1;
      end else if (armed_q &&
                   phase_cnt > ({2'b00, cfg_now.delay} + {2'b00, cfg_now.width})) begin
         pulse_q   = 1'b0;
         armed_q   = 1'b0;
         phase_cnt = '0;
      end
      // both counters saturate at all ones
      if (since_trig != '1) since_trig = since_trig + 1'b1;
      if (phase_cnt != '1) phase_cnt = phase_cnt + 1'b1;
      r.pulse_level = pulse_q;
      r.triggered   = fire;
      return r;
   endfunction

   // Result side: random stall bursts, none while idle_on is clear.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 13);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every accepted result word is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got pulse %0b trig %0b",
                     $time, rsp_pulse_level, rsp_triggered);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_pulse_level !== want.pulse_level) begin
               $display("%0t: pulse_level mismatch, expected %0b, got %0b",
                        $time, want.pulse_level, rsp_pulse_level);
               errors++;
            end
            if (rsp_triggered !== want.triggered) begin
               $display("%0t: triggered mismatch, expected %0b, got %0b",
                        $time, want.triggered, rsp_triggered);
               errors++;
            end
         end
      end
   end

   // One sample word. Valid stays up after acceptance only if the next call
   // raises it again in the same step; every other path lowers it.
   task automatic send_word(input logic [SMP_BITS-1:0] smp);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(predict_tick(smp));
   endtask

   // Flat run: equal neighbors never form a strict extremum.
   task automatic send_level(input int count, input logic [SMP_BITS-1:0] smp);
      for (int i = 0; i < count; i++) send_word(smp);
   endtask

   // Hold off the sender until every expected word is back, then settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MEAN:      cfg_now.mean   = data;
         CSR_SD:        cfg_now.sd     = data;
         CSR_THRESHOLD: cfg_now.thr    = data[THR_BITS-1:0];
         CSR_TROUGH:    cfg_now.trough = data[0];
         CSR_WIDTH:     cfg_now.width  = data;
         CSR_DELAY:     cfg_now.delay  = data;
         CSR_HOLDOFF:   cfg_now.hold   = data;
         default: ;
      endcase
   endtask

   // Full register set, written only with the block drained. Unused upper data
   // bits of the narrow registers and the spare index carry random junk.
   task automatic apply_settings(input logic [CFG_BITS-1:0] mean, sd,
                                 input logic signed [THR_BITS-1:0] thr,
                                 input logic trough,
                                 input logic [CFG_BITS-1:0] width, delay, hold);
      wait_drained();
      write_reg(CSR_UNUSED, 16'($urandom));
      write_reg(CSR_MEAN, mean);
      write_reg(CSR_SD, sd);
      write_reg(CSR_THRESHOLD, {5'($urandom), thr});
      write_reg(CSR_TROUGH, {15'($urandom), trough});
      write_reg(CSR_WIDTH, width);
      write_reg(CSR_DELAY, delay);
      write_reg(CSR_HOLDOFF, hold);
      csr_valid <= 1'b0;
   endtask

   // Reset settings: extremes of the sample, then one clean peak past the gap.
   // Lead-in runs below count on the tail of the test before them.
   task automatic test_default_peak();
      send_word(12'd0);
      send_word(12'hFFF);
      send_word(12'd0);
      send_word(12'hFFF);
      send_level(100, 12'd0);
      send_word(12'hFFF);
      send_word(12'd0);
      send_level(14, 12'd0);
   endtask

   // mid * 100 equal to the level must not fire, one LSB more must.
   task automatic test_threshold_boundary();
      apply_settings(16'd0, 16'd16, 11'sd100, 1'b0, 16'd4, 16'd1, 16'd0);
      send_level(86, 12'd0);
      send_word(12'd1);
      send_word(12'd0);
      send_word(12'd2);
      send_word(12'd0);
      send_level(8, 12'd0);
   endtask

   // Most negative level with largest mean/sd/timers (trough can never fire),
   // then the most positive level with sd of one and a pulse that outlasts the test.
   task automatic test_level_extremes();
      apply_settings(16'hFFFF, 16'hFFFF, 11'h400, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(12'hFFF);
      send_word(12'd0);
      send_word(12'hFFF);
      send_word(12'd0);
      send_level(3, 12'hFFF);
      apply_settings(16'd0, 16'd1, 11'h3FF, 1'b0, 16'hFFFF, 16'd0, 16'd0);
      send_level(86, 12'd0);
      send_word(12'd1);
      send_word(12'd0);
      send_level(5, 12'd0);
   endtask

   // sd of zero behaves as one; also ends the long pulse left armed before.
   task automatic test_zero_deviation();
      apply_settings(16'd16, 16'd0, 11'sd1, 1'b0, 16'd6, 16'd0, 16'd0);
      send_level(95, 12'd1);
      send_word(12'd2);
      send_word(12'd1);
      send_level(9, 12'd1);
   endtask

   // Zero width: line high for a single tick after the delay.
   task automatic test_zero_width();
      apply_settings(16'd0, 16'd16, 11'sd0, 1'b0, 16'd0, 16'd3, 16'd0);
      send_level(91, 12'd0);
      send_word(12'hFFF);
      send_word(12'd0);
      send_level(7, 12'd0);
   endtask

   // Second trigger lands while the line is still high and restarts the count;
   // without the restart the line would drop before the run ends.
   task automatic test_retrigger_while_high();
      apply_settings(16'd0, 16'd16, 11'sd50, 1'b0, 16'd105, 16'd2, 16'd0);
      send_level(93, 12'd0);
      send_word(12'hFFF);
      send_word(12'd0);
      send_level(101, 12'd0);
      send_word(12'hFFF);
      send_word(12'd0);
      send_level(12, 12'd0);
   endtask

   // Peaks every 30 ticks; one past the fixed gap is still inside the holdoff.
   task automatic test_holdoff();
      apply_settings(16'd0, 16'd16, 11'sd50, 1'b0, 16'd5, 16'd0, 16'd120);
      for (int i = 0; i < 5; i++) begin
         send_level(28, 12'd0);
         send_word(12'hFFF);
         send_word(12'd0);
      end
   endtask

   // Trough mode around a mid-scale mean; a peak must not fire, the dip does.
   task automatic test_trough();
      apply_settings(16'd32768, 16'd100, -11'sd50, 1'b1, 16'd8, 16'd4, 16'd0);
      send_level(80, 12'd2048);
      send_word(12'hFFF);
      send_word(12'd2048);
      send_word(12'd1000);
      send_word(12'd2048);
      send_level(14, 12'd2048);
   endtask

   // Random settings per phase; stream is noise around the mean with spikes,
   // mostly in the direction the mode detects, plus uniform and rail words.
   task automatic test_random_streams(input int phases, input int words);
      logic [CFG_BITS-1:0]        mean_v, sd_v, width_v, delay_v, hold_v;
      logic signed [THR_BITS-1:0] thr_v;
      logic                       trough_v;
      int                         base, amp, v, pick;
      for (int p = 0; p < phases; p++) begin
         mean_v   = 16'($urandom);
         sd_v     = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 3000));
         thr_v    = 11'($urandom);
         trough_v = 1'($urandom);
         width_v  = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 40));
         delay_v  = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 40));
         hold_v   = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 250));
         apply_settings(mean_v, sd_v, thr_v, trough_v, width_v, delay_v, hold_v);
         base = int'(mean_v >> 4);
         amp  = int'($urandom_range(1, 2047));
         for (int i = 0; i < words; i++) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 55)
               v = base + int'($urandom_range(0, amp / 4)) - amp / 8;
            else if (pick < 80)
               v = (($urandom_range(0, 3) != 0) ^ trough_v) ? base + amp : base - amp;
            else if (pick < 92)
               v = int'($urandom_range(0, 4095));
            else
               v = ($urandom_range(0, 1) == 1) ? 4095 : 0;
            if (v < 0)
               v = 0;
            else if (v > 4095)
               v = 4095;
            send_word(12'(v));
            // occasional full drain mid-stream
            if (idle_on && $urandom_range(0, 299) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_peak();
      test_threshold_boundary();
      test_level_extremes();
      test_zero_deviation();
      test_zero_width();
      test_retrigger_while_high();
      test_holdoff();
      test_trough();
      test_random_streams(1, 40);
      idle_on = 1'b0;
      test_random_streams(1, 40);
      idle_on = 1'b1;
      test_random_streams(1, 40);
      // closing stretch at full rate on both sides
      idle_on = 1'b0;
      test_random_streams(1, 40);
      wait_drained();
      if (errors == 0)
         $display("peak_triggered_delayed_pulse test passed");
      else
         $display("peak_triggered_delayed_pulse test failed");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("peak_triggered_delayed_pulse test failed");
      $finish;
   end

endmodule
